// File: hdl/hrf_pkg.sv
// shared types, codes and character constants of the http response framer
package hrf_pkg;

   // input kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_NEW   = 2'd2;

   // configuration register indexes
   localparam logic CSR_MAX_BODY = 1'b0;
   localparam logic CSR_IS_HEAD  = 1'b1;

   // end codes
   localparam logic [1:0] END_RUN  = 2'd0;
   localparam logic [1:0] END_OK   = 2'd1;
   localparam logic [1:0] END_BIG  = 2'd2;
   localparam logic [1:0] END_FAIL = 2'd3;

   // framing phases
   localparam logic [2:0] PH_HEADER     = 3'd0;
   localparam logic [2:0] PH_CHUNK_LINE = 3'd1;
   localparam logic [2:0] PH_CHUNK_DATA = 3'd2;
   localparam logic [2:0] PH_CL_BODY    = 3'd3;
   localparam logic [2:0] PH_EOF_BODY   = 3'd4;
   localparam logic [2:0] PH_DONE       = 3'd5;

   // line field states: status line below L_START, header lines from it
   localparam logic [4:0] ST_PROTO_END = 5'd5;
   localparam logic [4:0] ST_MAJ_WS  = 5'd5;
   localparam logic [4:0] ST_MAJ     = 5'd6;
   localparam logic [4:0] ST_MIN_WS  = 5'd7;
   localparam logic [4:0] ST_MIN     = 5'd8;
   localparam logic [4:0] ST_CODE_WS = 5'd9;
   localparam logic [4:0] ST_CODE    = 5'd10;
   localparam logic [4:0] ST_GOOD    = 5'd11;
   localparam logic [4:0] ST_BAD     = 5'd12;
   localparam logic [4:0] L_START    = 5'd16;
   localparam logic [4:0] L_TE       = 5'd17;
   localparam logic [4:0] L_CL       = 5'd18;
   localparam logic [4:0] L_TEVAL    = 5'd19;
   localparam logic [4:0] L_CLVAL    = 5'd20;
   localparam logic [4:0] L_SKIP     = 5'd21;

   // header flag bits
   localparam int F_TE_DONE   = 0;
   localparam int F_CHUNKED   = 1;
   localparam int F_CL_DONE   = 2;
   localparam int F_CL_HAVE   = 3;
   localparam int F_NUL       = 4;
   localparam int F_STATUS_OK = 5;

   // number parser states
   localparam logic [2:0] NS_WS   = 3'd0;
   localparam logic [2:0] NS_SIGN = 3'd1;
   localparam logic [2:0] NS_ZERO = 3'd2;
   localparam logic [2:0] NS_ZX   = 3'd3;
   localparam logic [2:0] NS_DEC  = 3'd4;
   localparam logic [2:0] NS_OCT  = 3'd5;
   localparam logic [2:0] NS_HEX  = 3'd6;
   localparam logic [2:0] NS_DONE = 3'd7;

   // characters
   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_CR  = 8'h0d;
   localparam logic [7:0] CH_LF  = 8'h0a;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_0 = 8'h30;
   localparam logic [7:0] CH_x = 8'h78;
   localparam logic [7:0] CH_X = 8'h58;
   localparam logic [7:0] CH_T = 8'h54;
   localparam logic [7:0] CH_C = 8'h43;
   localparam logic [7:0] CH_c = 8'h63;

   localparam logic [4:0] TE_LEN      = 5'd17;
   localparam logic [4:0] CL_LEN      = 5'd14;
   localparam logic [2:0] CHUNKED_LEN = 3'd7;

   localparam logic [9:0] STATUS_MAX = 10'd999;

   typedef struct packed {
      logic [31:0] max_body_length;
      logic        request_is_head;
   } cfg_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        body_valid;
      logic [7:0]  body_byte;
      logic [1:0]  end_code;
      logic [9:0]  status_code;
      logic [31:0] body_length;
   } rsp_type;

   // "HTTP/"
   function automatic logic [7:0] proto_char(input logic [2:0] i);
      case (i)
         3'd0: proto_char = 8'h48;
         3'd1: proto_char = 8'h54;
         3'd2: proto_char = 8'h54;
         3'd3: proto_char = 8'h50;
         3'd4: proto_char = 8'h2f;
         default: proto_char = 8'h00;
      endcase
   endfunction

   // "Transfer-Encoding"
   function automatic logic [7:0] te_char(input logic [4:0] i);
      case (i)
         5'd0: te_char = "T";  5'd1: te_char = "r";  5'd2: te_char = "a";
         5'd3: te_char = "n";  5'd4: te_char = "s";  5'd5: te_char = "f";
         5'd6: te_char = "e";  5'd7: te_char = "r";  5'd8: te_char = "-";
         5'd9: te_char = "E";  5'd10: te_char = "n"; 5'd11: te_char = "c";
         5'd12: te_char = "o"; 5'd13: te_char = "d"; 5'd14: te_char = "i";
         5'd15: te_char = "n"; 5'd16: te_char = "g";
         default: te_char = 8'h00;
      endcase
   endfunction

   // "Content-Length"
   function automatic logic [7:0] cl_char(input logic [4:0] i);
      case (i)
         5'd0: cl_char = "C";  5'd1: cl_char = "o";  5'd2: cl_char = "n";
         5'd3: cl_char = "t";  5'd4: cl_char = "e";  5'd5: cl_char = "n";
         5'd6: cl_char = "t";  5'd7: cl_char = "-";  5'd8: cl_char = "L";
         5'd9: cl_char = "e";  5'd10: cl_char = "n"; 5'd11: cl_char = "g";
         5'd12: cl_char = "t"; 5'd13: cl_char = "h";
         default: cl_char = 8'h00;
      endcase
   endfunction

   // "chunked"
   function automatic logic [7:0] chunked_char(input logic [2:0] i);
      case (i)
         3'd0: chunked_char = "c"; 3'd1: chunked_char = "h";
         3'd2: chunked_char = "u"; 3'd3: chunked_char = "n";
         3'd4: chunked_char = "k"; 3'd5: chunked_char = "e";
         3'd6: chunked_char = "d";
         default: chunked_char = 8'h00;
      endcase
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      is_space = (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   // hex digit value, 16 when not a digit
   function automatic logic [4:0] digit_of(input logic [7:0] b);
      if (b >= "0" && b <= "9") digit_of = 5'(b - "0");
      else if (b >= "a" && b <= "f") digit_of = 5'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") digit_of = 5'(b - "A" + 8'd10);
      else digit_of = 5'd16;
   endfunction

endpackage

// File: hdl/hrf_core.sv
// parser state and combinational next-state logic for one word
module hrf_core #(
   parameter int MAX_HEADER_BYTES = 65536,
   parameter int MAX_CHUNK_LINE   = 256,
   parameter int LENGTH_BITS      = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_accept,
   input  hrf_pkg::req_type in_item,
   input  hrf_pkg::cfg_type cfg,
   output logic             res_valid,
   output hrf_pkg::rsp_type res
);

   localparam int AW  = LENGTH_BITS + 1;
   localparam int HBW = $clog2(MAX_HEADER_BYTES + 2);
   localparam int CLW = $clog2(MAX_CHUNK_LINE + 1);
   localparam int CW  = (LENGTH_BITS > 32) ? LENGTH_BITS + 2 : 34;
   localparam logic [AW-1:0] CAP = {1'b1, {LENGTH_BITS{1'b0}}};

   typedef struct packed {
      logic [2:0]    ns;
      logic          neg;
      logic [AW-1:0] acc;
   } num_type;

   typedef struct packed {
      logic [4:0] lfs;
      logic [4:0] nidx;
      logic [2:0] cm;
      logic [5:0] flags;
      logic [9:0] st;
      num_type    num;
   } hdr_type;

   localparam num_type NUM_START = '{ns: hrf_pkg::NS_WS, neg: 1'b0, acc: '0};

   // accumulate one digit, saturating at the length cap
   function automatic logic [AW-1:0] push_digit(input logic [AW-1:0] a,
                                                input logic [4:0] d,
                                                input logic [2:0] ns);
      logic [AW+3:0] ax;
      logic [AW+3:0] prod;
      logic [AW+3:0] sum;
      ax = {4'b0, a};
      case (ns)
         hrf_pkg::NS_HEX: prod = ax << 4;
         hrf_pkg::NS_OCT: prod = ax << 3;
         default:         prod = (ax << 3) + (ax << 1);
      endcase
      sum = prod + {{(AW-1){1'b0}}, d};
      if (a >= CAP || sum > {4'b0, CAP}) push_digit = CAP;
      else push_digit = sum[AW-1:0];
   endfunction

   // strtoull style number parser, base 0 or base 16
   function automatic num_type num_feed(input num_type n, input logic [7:0] b,
                                        input logic hex);
      num_type    r;
      logic [4:0] d;
      logic [4:0] lim;
      r = n;
      d = hrf_pkg::digit_of(b);
      lim = hex ? 5'd16 : 5'd10;
      if (r.ns == hrf_pkg::NS_WS) begin
         if (hrf_pkg::is_space(b)) return r;
         if (b == hrf_pkg::CH_PLUS || b == hrf_pkg::CH_MINUS) begin
            r.neg = (b == hrf_pkg::CH_MINUS);
            r.ns  = hrf_pkg::NS_SIGN;
            return r;
         end
         r.ns = hrf_pkg::NS_SIGN;
      end
      case (r.ns)
         hrf_pkg::NS_SIGN: begin
            if (b == hrf_pkg::CH_0) r.ns = hrf_pkg::NS_ZERO;
            else if (d < lim) begin
               r.acc = AW'(d);
               r.ns  = hex ? hrf_pkg::NS_HEX : hrf_pkg::NS_DEC;
            end else r.ns = hrf_pkg::NS_DONE;
         end
         hrf_pkg::NS_ZERO: begin
            if (b == hrf_pkg::CH_x || b == hrf_pkg::CH_X) r.ns = hrf_pkg::NS_ZX;
            else if (hex && d < 5'd16) begin
               r.acc = AW'(d);
               r.ns  = hrf_pkg::NS_HEX;
            end else if (!hex && d < 5'd8) begin
               r.acc = AW'(d);
               r.ns  = hrf_pkg::NS_OCT;
            end else r.ns = hrf_pkg::NS_DONE;
         end
         hrf_pkg::NS_ZX: begin
            if (d < 5'd16) begin
               r.acc = AW'(d);
               r.ns  = hrf_pkg::NS_HEX;
            end else r.ns = hrf_pkg::NS_DONE;
         end
         hrf_pkg::NS_DEC: begin
            if (d < 5'd10) r.acc = push_digit(r.acc, d, r.ns);
            else r.ns = hrf_pkg::NS_DONE;
         end
         hrf_pkg::NS_OCT: begin
            if (d < 5'd8) r.acc = push_digit(r.acc, d, r.ns);
            else r.ns = hrf_pkg::NS_DONE;
         end
         hrf_pkg::NS_HEX: begin
            if (d < 5'd16) r.acc = push_digit(r.acc, d, r.ns);
            else r.ns = hrf_pkg::NS_DONE;
         end
         default: r.ns = hrf_pkg::NS_DONE;
      endcase
      return r;
   endfunction

   function automatic logic [AW-1:0] num_value(input num_type n);
      if (n.neg && n.acc != '0) num_value = CAP;
      else num_value = n.acc;
   endfunction

   // status line: "HTTP/" major "." minor code
   function automatic hdr_type status_feed(input hdr_type h, input logic [7:0] b);
      hdr_type    r;
      logic [4:0] d;
      logic       dig;
      logic [13:0] sx;
      r = h;
      d = hrf_pkg::digit_of(b);
      dig = d < 5'd10;
      sx = 14'(h.st) * 14'd10 + 14'(d);
      if (h.lfs < hrf_pkg::ST_PROTO_END) begin
         r.lfs = (b == hrf_pkg::proto_char(h.lfs[2:0])) ? h.lfs + 5'd1 : hrf_pkg::ST_BAD;
      end else begin
         case (h.lfs)
            hrf_pkg::ST_MAJ_WS: begin
               if (dig) begin
                  r.num.acc = AW'(d);
                  r.lfs = hrf_pkg::ST_MAJ;
               end else if (!hrf_pkg::is_space(b)) r.lfs = hrf_pkg::ST_BAD;
            end
            hrf_pkg::ST_MAJ: begin
               // major number only needs to tell one from anything else
               if (dig) r.num.acc = (h.num.acc * AW'(10) + AW'(d) > AW'(2)) ? AW'(2)
                                  : h.num.acc * AW'(10) + AW'(d);
               else if (b == hrf_pkg::CH_DOT && h.num.acc == AW'(1))
                  r.lfs = hrf_pkg::ST_MIN_WS;
               else r.lfs = hrf_pkg::ST_BAD;
            end
            hrf_pkg::ST_MIN_WS: begin
               if (dig) r.lfs = hrf_pkg::ST_MIN;
               else if (!hrf_pkg::is_space(b)) r.lfs = hrf_pkg::ST_BAD;
            end
            hrf_pkg::ST_MIN: begin
               if (hrf_pkg::is_space(b)) r.lfs = hrf_pkg::ST_CODE_WS;
               else if (!dig) r.lfs = hrf_pkg::ST_BAD;
            end
            hrf_pkg::ST_CODE_WS: begin
               if (dig) begin
                  r.st  = 10'(d);
                  r.lfs = hrf_pkg::ST_CODE;
               end else if (!hrf_pkg::is_space(b)) r.lfs = hrf_pkg::ST_BAD;
            end
            hrf_pkg::ST_CODE: begin
               if (dig) r.st = (sx > 14'(hrf_pkg::STATUS_MAX)) ? hrf_pkg::STATUS_MAX
                             : sx[9:0];
               else r.lfs = hrf_pkg::ST_GOOD;
            end
            default: r = h;
         endcase
      end
      return r;
   endfunction

   // one header octet that is not part of a line end
   function automatic hdr_type hdr_feed(input hdr_type h, input logic [7:0] b);
      hdr_type r;
      logic    is_te;
      logic [4:0] len;
      logic [7:0] nch;
      logic [2:0] cmn;
      r = h;
      if (b == hrf_pkg::CH_NUL) r.flags[hrf_pkg::F_NUL] = 1'b1;
      is_te = (h.lfs == hrf_pkg::L_TE);
      len = is_te ? hrf_pkg::TE_LEN : hrf_pkg::CL_LEN;
      nch = is_te ? hrf_pkg::te_char(h.nidx) : hrf_pkg::cl_char(h.nidx);
      if (h.lfs < hrf_pkg::L_START) return status_feed(r, b);
      case (h.lfs)
         hrf_pkg::L_START: begin
            r.nidx = 5'd1;
            r.lfs = (b == hrf_pkg::CH_T) ? hrf_pkg::L_TE
                  : (b == hrf_pkg::CH_C) ? hrf_pkg::L_CL : hrf_pkg::L_SKIP;
         end
         hrf_pkg::L_TE, hrf_pkg::L_CL: begin
            if (b == hrf_pkg::CH_COLON) begin
               if (h.nidx == len && !h.flags[is_te ? hrf_pkg::F_TE_DONE
                                                   : hrf_pkg::F_CL_DONE]) begin
                  r.flags[is_te ? hrf_pkg::F_TE_DONE : hrf_pkg::F_CL_DONE] = 1'b1;
                  r.cm  = '0;
                  r.num = NUM_START;
                  r.lfs = is_te ? hrf_pkg::L_TEVAL : hrf_pkg::L_CLVAL;
               end else r.lfs = hrf_pkg::L_SKIP;
            end else if (h.nidx < len && b == nch) r.nidx = h.nidx + 5'd1;
            else r.lfs = hrf_pkg::L_SKIP;
         end
         hrf_pkg::L_TEVAL: begin
            if (h.cm < hrf_pkg::CHUNKED_LEN && b == hrf_pkg::chunked_char(h.cm))
               cmn = h.cm + 3'd1;
            else cmn = (b == hrf_pkg::CH_c) ? 3'd1 : 3'd0;
            r.cm = cmn;
            if (cmn == hrf_pkg::CHUNKED_LEN) begin
               r.flags[hrf_pkg::F_CHUNKED] = 1'b1;
               r.lfs = hrf_pkg::L_SKIP;
            end
         end
         hrf_pkg::L_CLVAL: r.num = num_feed(h.num, b, 1'b0);
         default: r = r;
      endcase
      return r;
   endfunction

   logic [2:0]     phase_ff, phase_in;
   logic [HBW-1:0] hbc_ff, hbc_in;
   logic [1:0]     lt_ff, lt_in;
   hdr_type        hdr_ff, hdr_in;
   logic [AW-1:0]  rem_ff, rem_in;
   logic [31:0]    dl_ff, dl_in;
   logic [CLW-1:0] clc_ff, clc_in;

   logic       do_emit;
   logic       e_valid;
   logic [1:0] e_code;
   logic [7:0] b;
   hdr_type    h;
   logic [AW-1:0] v;
   logic [CW-1:0] dl_plus_v;

   assign b = in_item.data_byte;

   // next state and result for the accepted word
   always_comb begin
      phase_in = phase_ff;
      hbc_in   = hbc_ff;
      lt_in    = lt_ff;
      hdr_in   = hdr_ff;
      rem_in   = rem_ff;
      dl_in    = dl_ff;
      clc_in   = clc_ff;
      do_emit  = 1'b0;
      e_valid  = 1'b0;
      e_code   = hrf_pkg::END_RUN;
      h        = hdr_ff;
      v        = num_value(hdr_ff.num);
      dl_plus_v = CW'(dl_ff) + CW'(v);
      if (in_accept) begin
         if (in_item.kind == hrf_pkg::KIND_NEW) begin
            phase_in = hrf_pkg::PH_HEADER;
            hbc_in = '0;
            lt_in  = '0;
            hdr_in = '0;
            rem_in = '0;
            dl_in  = '0;
            clc_in = '0;
         end else if (in_item.kind == 2'd3 || phase_ff == hrf_pkg::PH_DONE) begin
            phase_in = phase_ff;
         end else if (in_item.kind == hrf_pkg::KIND_CLOSE) begin
            do_emit = 1'b1;
            e_code = (phase_ff == hrf_pkg::PH_EOF_BODY) ? hrf_pkg::END_OK
                                                        : hrf_pkg::END_FAIL;
         end else begin
            case (phase_ff)
               hrf_pkg::PH_HEADER: begin
                  if (hbc_ff <= HBW'(MAX_HEADER_BYTES)) hbc_in = hbc_ff + HBW'(1);
                  if (lt_ff[0] && b == hrf_pkg::CH_LF && lt_ff == 2'd3) begin
                     // end of header
                     if (hdr_ff.flags[hrf_pkg::F_NUL] || !hdr_ff.flags[hrf_pkg::F_STATUS_OK])
                     begin
                        do_emit = 1'b1;
                        e_code = hrf_pkg::END_FAIL;
                     end else if (hdr_ff.st >= 10'd100 && hdr_ff.st <= 10'd199) begin
                        // informational: parse a fresh header
                        hbc_in = '0;
                        lt_in  = '0;
                        hdr_in = '0;
                        rem_in = '0;
                     end else if (cfg.request_is_head || hdr_ff.st == 10'd204 ||
                                  hdr_ff.st == 10'd304) begin
                        do_emit = 1'b1;
                        e_code = hrf_pkg::END_OK;
                     end else if (hdr_ff.flags[hrf_pkg::F_CHUNKED]) begin
                        phase_in = hrf_pkg::PH_CHUNK_LINE;
                        lt_in = '0;
                        clc_in = '0;
                        hdr_in.num = NUM_START;
                     end else if (hdr_ff.flags[hrf_pkg::F_CL_HAVE]) begin
                        if (rem_ff >= CAP || CW'(rem_ff) > CW'(cfg.max_body_length)) begin
                           do_emit = 1'b1;
                           e_code = hrf_pkg::END_BIG;
                        end else if (rem_ff == '0) begin
                           do_emit = 1'b1;
                           e_code = hrf_pkg::END_OK;
                        end else phase_in = hrf_pkg::PH_CL_BODY;
                     end else phase_in = hrf_pkg::PH_EOF_BODY;
                  end else begin
                     if (lt_ff[0] && b == hrf_pkg::CH_LF) begin
                        // end of one header line
                        if (hdr_ff.lfs < hrf_pkg::L_START) begin
                           if (hdr_ff.lfs == hrf_pkg::ST_CODE || hdr_ff.lfs == hrf_pkg::ST_GOOD)
                              h.flags[hrf_pkg::F_STATUS_OK] = 1'b1;
                        end else if (hdr_ff.lfs == hrf_pkg::L_TE &&
                                     hdr_ff.nidx == hrf_pkg::TE_LEN) begin
                           h.flags[hrf_pkg::F_TE_DONE] = 1'b1;
                        end else if (hdr_ff.lfs == hrf_pkg::L_CL &&
                                     hdr_ff.nidx == hrf_pkg::CL_LEN) begin
                           h.flags[hrf_pkg::F_CL_DONE] = 1'b1;
                        end else if (hdr_ff.lfs == hrf_pkg::L_CLVAL) begin
                           h.flags[hrf_pkg::F_CL_HAVE] = 1'b1;
                           rem_in = v;
                        end
                        h.lfs = hrf_pkg::L_START;
                        lt_in = 2'd2;
                     end else begin
                        if (lt_ff[0]) h = hdr_feed(h, hrf_pkg::CH_CR);
                        if (b == hrf_pkg::CH_CR) lt_in = (lt_ff == 2'd2) ? 2'd3 : 2'd1;
                        else begin
                           h = hdr_feed(h, b);
                           lt_in = 2'd0;
                        end
                     end
                     hdr_in = h;
                     if (hbc_in > HBW'(MAX_HEADER_BYTES)) begin
                        do_emit = 1'b1;
                        e_code = hrf_pkg::END_FAIL;
                     end
                  end
               end
               hrf_pkg::PH_CHUNK_LINE: begin
                  clc_in = clc_ff + CLW'(1);
                  if (lt_ff == 2'd1 && b == hrf_pkg::CH_LF) begin
                     if (v == '0) begin
                        do_emit = 1'b1;
                        e_code = hrf_pkg::END_OK;
                     end else if (v >= CAP || dl_plus_v > CW'(cfg.max_body_length)) begin
                        do_emit = 1'b1;
                        e_code = hrf_pkg::END_BIG;
                     end else begin
                        rem_in = v + AW'(2);
                        phase_in = hrf_pkg::PH_CHUNK_DATA;
                     end
                  end else begin
                     if (lt_ff == 2'd1) h.num = num_feed(h.num, hrf_pkg::CH_CR, 1'b1);
                     if (b == hrf_pkg::CH_CR) lt_in = 2'd1;
                     else begin
                        h.num = num_feed(h.num, b, 1'b1);
                        lt_in = 2'd0;
                     end
                     hdr_in = h;
                     if (clc_in >= CLW'(MAX_CHUNK_LINE)) begin
                        do_emit = 1'b1;
                        e_code = hrf_pkg::END_FAIL;
                     end
                  end
               end
               hrf_pkg::PH_CHUNK_DATA: begin
                  if (rem_ff > AW'(2)) begin
                     rem_in = rem_ff - AW'(1);
                     dl_in = dl_ff + 32'd1;
                     do_emit = 1'b1;
                     e_valid = 1'b1;
                  end else begin
                     // trailing line end of the chunk is dropped unchecked
                     rem_in = (rem_ff != '0) ? rem_ff - AW'(1) : rem_ff;
                     if (rem_in == '0) begin
                        phase_in = hrf_pkg::PH_CHUNK_LINE;
                        lt_in = '0;
                        clc_in = '0;
                        hdr_in.num = NUM_START;
                     end
                  end
               end
               hrf_pkg::PH_CL_BODY: begin
                  rem_in = (rem_ff != '0) ? rem_ff - AW'(1) : rem_ff;
                  dl_in = dl_ff + 32'd1;
                  do_emit = 1'b1;
                  e_valid = 1'b1;
                  e_code = (rem_in == '0) ? hrf_pkg::END_OK : hrf_pkg::END_RUN;
               end
               hrf_pkg::PH_EOF_BODY: begin
                  do_emit = 1'b1;
                  if (dl_ff >= cfg.max_body_length) e_code = hrf_pkg::END_BIG;
                  else begin
                     dl_in = dl_ff + 32'd1;
                     e_valid = 1'b1;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
         if (do_emit && e_code != hrf_pkg::END_RUN) phase_in = hrf_pkg::PH_DONE;
      end
   end

   assign res_valid       = do_emit;
   assign res.body_valid  = e_valid;
   assign res.body_byte   = e_valid ? b : 8'd0;
   assign res.end_code    = e_code;
   assign res.status_code = hdr_in.st;
   assign res.body_length = dl_in;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hrf_pkg::PH_HEADER;
         hbc_ff   <= '0;
         lt_ff    <= '0;
         hdr_ff   <= '0;
         rem_ff   <= '0;
         dl_ff    <= '0;
         clc_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         hbc_ff   <= hbc_in;
         lt_ff    <= lt_in;
         hdr_ff   <= hdr_in;
         rem_ff   <= rem_in;
         dl_ff    <= dl_in;
         clc_ff   <= clc_in;
      end
   end

   a_end_to_done: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.end_code != hrf_pkg::END_RUN |=> phase_ff == hrf_pkg::PH_DONE)
      else $error("end code given but framer not finished");

   a_quiet_when_done: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hrf_pkg::PH_DONE && in_item.kind != hrf_pkg::KIND_NEW |-> !res_valid)
      else $error("result produced after end of response");

   a_length_steps: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.body_valid |-> res.body_length == dl_ff + 32'd1)
      else $error("body length did not advance with body word");

endmodule

// File: hdl/hrf_out_buf.sv
// two-entry result buffer between the framer core and the result channel
module hrf_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hrf_pkg::rsp_type push_item,
   output logic             has_room,
   output logic             out_valid,
   input  logic             out_ready,
   output hrf_pkg::rsp_type out_item
);

   hrf_pkg::rsp_type ent_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign has_room  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item  = ent_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= push_item;
   end

endmodule

// File: hdl/http_response_framer.sv
// HTTP/1.1 response framer: one received word per cycle, at most one result per word.
// Each accepted word is parsed in the cycle it is taken and its result, if any, lands in a
// two-entry output buffer, so a word can be accepted every cycle while results are taken;
// req_tready drops only when both buffer entries hold results not yet taken. Each result is
// registered in the output buffer before rsp_tvalid shows it. The parser state update is a
// single short pass of matchers and shift-add counters, which sets the one-word-per-cycle rate.
module http_response_framer #(
   parameter int MAX_HEADER_BYTES = 65536,
   parameter int MAX_CHUNK_LINE   = 256,
   parameter int LENGTH_BITS      = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // body_byte[7:0], end_code[9:8], status_code[19:10],
                                    // body_length[51:20], zero fill[55:52]
   output logic        rsp_tuser,   // body_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data
);

   hrf_pkg::cfg_type cfg_ff;
   hrf_pkg::req_type req;
   hrf_pkg::rsp_type core_res;
   hrf_pkg::rsp_type out_item;
   logic core_valid;
   logic accept;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;
   assign req.kind      = req_tuser;
   assign req.data_byte = req_tdata;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_body_length <= 32'hFFFF_FFFF;
         cfg_ff.request_is_head <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hrf_pkg::CSR_MAX_BODY: cfg_ff.max_body_length <= csr_data;
            hrf_pkg::CSR_IS_HEAD:  cfg_ff.request_is_head <= csr_data[0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   hrf_core #(
      .MAX_HEADER_BYTES(MAX_HEADER_BYTES),
      .MAX_CHUNK_LINE  (MAX_CHUNK_LINE),
      .LENGTH_BITS     (LENGTH_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_accept(accept),
      .in_item  (req),
      .cfg      (cfg_ff),
      .res_valid(core_valid),
      .res      (core_res)
   );

   hrf_out_buf u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (core_valid),
      .push_item(core_res),
      .has_room (req_tready),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_item (out_item)
   );

   // pack result word
   assign rsp_tuser = out_item.body_valid;
   assign rsp_tdata = {4'b0, out_item.body_length, out_item.status_code,
                       out_item.end_code, out_item.body_byte};

endmodule

// File: tb/testbench.sv
// self-checking testbench for the http response framer: scripted and random responses
module testbench;
   import hrf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          HDR_LIMIT  = 65536;
   localparam int          CHUNK_LINE = 256;
   localparam longint unsigned LEN_CAP = 64'h1_0000_0000;
   localparam int          CYCLE_LIMIT = 3000000;

   // one planned word: a stream word or a register write
   typedef struct {
      bit          is_csr;
      logic        index;
      logic [31:0] value;
      logic [1:0]  kind;
      logic [7:0]  octet;
   } plan_word_t;

   typedef struct {
      logic        body_valid;
      logic [7:0]  body_byte;
      logic [1:0]  end_code;
      logic [9:0]  status_code;
      logic [31:0] body_length;
   } frame_event_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // data_byte[7:0]
   logic [1:0]  req_tuser = 2'd0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;          // body_byte, end_code, status_code, body_length, zero fill
   logic        rsp_tuser;          // body_valid
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [31:0] csr_data = 32'd0;

   http_response_framer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   plan_word_t   word_plan[$];
   frame_event_t frame_events[$];
   int errors = 0;
   int words_taken = 0;
   int events_seen = 0;
   int responses = 0;
   int cycles = 0;

   string proto_txt   = "HTTP/";
   string te_txt      = "Transfer-Encoding";
   string cl_txt      = "Content-Length";
   string chunked_txt = "chunked";

   // predicted framer state
   logic [31:0] max_len;
   logic        is_head;
   logic [2:0]  phase;
   logic [1:0]  tail;
   logic [4:0]  field_st;
   int          name_pos, chunk_pos;
   logic [5:0]  flags;
   logic [2:0]  nstate;
   bit          nneg;
   longint unsigned nacc, remaining;
   int unsigned hdr_count, chunk_count, status_reg;
   longint unsigned delivered;

   function automatic bit blank(logic [7:0] b);
      return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic int unsigned digit_val(logic [7:0] b);
      if (b >= "0" && b <= "9") return b - "0";
      if (b >= "a" && b <= "f") return b - "a" + 10;
      if (b >= "A" && b <= "F") return b - "A" + 10;
      return 16;
   endfunction

   function automatic longint unsigned add_digit(longint unsigned a, int unsigned d,
                                                 int unsigned base);
      if (a >= LEN_CAP || a > (LEN_CAP - d) / base) return LEN_CAP;
      return a * base + d;
   endfunction

   function automatic void number_clear();
      nstate = NS_WS;
      nneg = 0;
      nacc = 0;
   endfunction

   // strtoull-like number parser, one character at a time
   function automatic void number_push(logic [7:0] b, bit hex);
      int unsigned d, base;
      d = digit_val(b);
      base = 0;
      if (nstate == NS_WS) begin
         if (blank(b)) return;
         if (b == CH_PLUS || b == CH_MINUS) begin
            nneg = (b == CH_MINUS);
            nstate = NS_SIGN;
            return;
         end
         nstate = NS_SIGN;
      end
      if (nstate == NS_SIGN) begin
         if (b == CH_0) nstate = NS_ZERO;
         else if (d < (hex ? 16 : 10)) begin
            nacc = d;
            nstate = hex ? NS_HEX : NS_DEC;
         end else nstate = NS_DONE;
         return;
      end
      if (nstate == NS_ZERO) begin
         if (b == CH_x || b == CH_X) nstate = NS_ZX;
         else if (hex && d < 16) begin nacc = d; nstate = NS_HEX; end
         else if (!hex && d < 8) begin nacc = d; nstate = NS_OCT; end
         else nstate = NS_DONE;
         return;
      end
      if (nstate == NS_ZX) begin
         if (d < 16) begin nacc = d; nstate = NS_HEX; end
         else nstate = NS_DONE;
         return;
      end
      if (nstate == NS_DEC) base = 10;
      else if (nstate == NS_OCT) base = 8;
      else if (nstate == NS_HEX) base = 16;
      if (base != 0 && d < base) nacc = add_digit(nacc, d, base);
      else nstate = NS_DONE;
   endfunction

   function automatic longint unsigned number_value();
      if (nneg && nacc != 0) return LEN_CAP;
      return nacc;
   endfunction

   function automatic void header_clear();
      hdr_count = 0;
      tail = 0;
      field_st = 0;
      name_pos = 0;
      chunk_pos = 0;
      flags = 0;
      status_reg = 0;
      remaining = 0;
      number_clear();
   endfunction

   function automatic void framer_clear();
      header_clear();
      phase = PH_HEADER;
      delivered = 0;
      chunk_count = 0;
   endfunction

   function automatic void expect_event(bit valid, logic [7:0] b, logic [1:0] code);
      frame_event_t e;
      e.body_valid = valid;
      e.body_byte = valid ? b : 8'd0;
      e.end_code = code;
      e.status_code = status_reg[9:0];
      e.body_length = delivered[31:0];
      frame_events.push_back(e);
      if (code != END_RUN) phase = PH_DONE;
   endfunction

   // status line: HTTP/ major . minor code
   function automatic void status_push(logic [7:0] b);
      int unsigned d;
      bit dig;
      d = digit_val(b);
      dig = d < 10;
      if (field_st < ST_PROTO_END) begin
         field_st = (b == proto_txt[field_st]) ? field_st + 5'd1 : ST_BAD;
      end else if (field_st == ST_MAJ_WS) begin
         if (dig) begin nacc = d; field_st = ST_MAJ; end
         else if (!blank(b)) field_st = ST_BAD;
      end else if (field_st == ST_MAJ) begin
         if (dig) begin
            nacc = nacc * 10 + d;
            if (nacc > 2) nacc = 2;
         end else if (b == CH_DOT && nacc == 1) field_st = ST_MIN_WS;
         else field_st = ST_BAD;
      end else if (field_st == ST_MIN_WS) begin
         if (dig) field_st = ST_MIN;
         else if (!blank(b)) field_st = ST_BAD;
      end else if (field_st == ST_MIN) begin
         if (blank(b)) field_st = ST_CODE_WS;
         else if (!dig) field_st = ST_BAD;
      end else if (field_st == ST_CODE_WS) begin
         if (dig) begin status_reg = d; field_st = ST_CODE; end
         else if (!blank(b)) field_st = ST_BAD;
      end else if (field_st == ST_CODE) begin
         if (dig) begin
            status_reg = status_reg * 10 + d;
            if (status_reg > 999) status_reg = 999;
         end else field_st = ST_GOOD;
      end
   endfunction

   function automatic void name_push(logic [7:0] b, string nm, int done_bit,
                                     logic [4:0] value_st);
      if (b == CH_COLON) begin
         if (name_pos == nm.len() && !flags[done_bit]) begin
            flags[done_bit] = 1'b1;
            chunk_pos = 0;
            number_clear();
            field_st = value_st;
         end else field_st = L_SKIP;
      end else if (name_pos < nm.len() && b == nm[name_pos]) name_pos++;
      else field_st = L_SKIP;
   endfunction

   function automatic void header_char(logic [7:0] b);
      if (b == CH_NUL) flags[F_NUL] = 1'b1;
      if (field_st < L_START) begin
         status_push(b);
         return;
      end
      if (field_st == L_START) begin
         name_pos = 1;
         field_st = (b == CH_T) ? L_TE : (b == CH_C) ? L_CL : L_SKIP;
      end else if (field_st == L_TE) name_push(b, te_txt, F_TE_DONE, L_TEVAL);
      else if (field_st == L_CL) name_push(b, cl_txt, F_CL_DONE, L_CLVAL);
      else if (field_st == L_TEVAL) begin
         if (chunk_pos < chunked_txt.len() && b == chunked_txt[chunk_pos]) chunk_pos++;
         else chunk_pos = (b == CH_c) ? 1 : 0;
         if (chunk_pos == chunked_txt.len()) begin
            flags[F_CHUNKED] = 1'b1;
            field_st = L_SKIP;
         end
      end else if (field_st == L_CLVAL) number_push(b, 0);
   endfunction

   function automatic void line_done();
      if (field_st < L_START) begin
         if (field_st == ST_CODE || field_st == ST_GOOD) flags[F_STATUS_OK] = 1'b1;
      end else if (field_st == L_TE && name_pos == te_txt.len()) flags[F_TE_DONE] = 1'b1;
      else if (field_st == L_CL && name_pos == cl_txt.len()) flags[F_CL_DONE] = 1'b1;
      else if (field_st == L_CLVAL) begin
         flags[F_CL_HAVE] = 1'b1;
         remaining = number_value();
      end
      field_st = L_START;
   endfunction

   function automatic void chunk_begin();
      phase = PH_CHUNK_LINE;
      tail = 0;
      chunk_count = 0;
      number_clear();
   endfunction

   // blank line seen: decide how the body is framed
   function automatic void header_end();
      if (flags[F_NUL] || !flags[F_STATUS_OK]) expect_event(0, 0, END_FAIL);
      else if (status_reg >= 100 && status_reg <= 199) header_clear();
      else if (is_head || status_reg == 204 || status_reg == 304) expect_event(0, 0, END_OK);
      else if (flags[F_CHUNKED]) chunk_begin();
      else if (flags[F_CL_HAVE]) begin
         if (remaining >= LEN_CAP || remaining > max_len) expect_event(0, 0, END_BIG);
         else if (remaining == 0) expect_event(0, 0, END_OK);
         else phase = PH_CL_BODY;
      end else phase = PH_EOF_BODY;
   endfunction

   function automatic void header_octet(logic [7:0] b);
      logic [1:0] t;
      t = tail;
      if (hdr_count <= HDR_LIMIT) hdr_count++;
      if (t[0] && b == CH_LF) begin
         if (t == 2'd3) begin
            header_end();
            return;
         end
         line_done();
         tail = 2;
      end else begin
         if (t[0]) header_char(CH_CR);
         if (b == CH_CR) tail = (t == 2'd2) ? 2'd3 : 2'd1;
         else begin
            header_char(b);
            tail = 0;
         end
      end
      if (hdr_count > HDR_LIMIT) expect_event(0, 0, END_FAIL);
   endfunction

   function automatic void chunk_line_octet(logic [7:0] b);
      longint unsigned v;
      chunk_count++;
      if (tail == 2'd1 && b == CH_LF) begin
         v = number_value();
         if (v == 0) expect_event(0, 0, END_OK);
         else if (v >= LEN_CAP || delivered + v > max_len) expect_event(0, 0, END_BIG);
         else begin
            remaining = v + 2;
            phase = PH_CHUNK_DATA;
         end
         return;
      end
      if (tail == 2'd1) number_push(CH_CR, 1);
      if (b == CH_CR) tail = 1;
      else begin
         number_push(b, 1);
         tail = 0;
      end
      if (chunk_count >= CHUNK_LINE) expect_event(0, 0, END_FAIL);
   endfunction

   // predict the effect of one accepted word
   function automatic void frame_word(logic [1:0] kind, logic [7:0] b);
      if (kind == KIND_NEW) begin
         framer_clear();
         return;
      end
      if (kind == 2'd3 || phase == PH_DONE) return;
      if (kind == KIND_CLOSE) begin
         expect_event(0, 0, phase == PH_EOF_BODY ? END_OK : END_FAIL);
         return;
      end
      case (phase)
         PH_HEADER: header_octet(b);
         PH_CHUNK_LINE: chunk_line_octet(b);
         PH_CHUNK_DATA: begin
            if (remaining > 2) begin
               remaining--;
               delivered++;
               expect_event(1, b, END_RUN);
            end else begin
               if (remaining > 0) remaining--;
               if (remaining == 0) chunk_begin();
            end
         end
         PH_CL_BODY: begin
            if (remaining > 0) remaining--;
            delivered++;
            expect_event(1, b, remaining == 0 ? END_OK : END_RUN);
         end
         PH_EOF_BODY: begin
            if (delivered >= max_len) expect_event(0, 0, END_BIG);
            else begin
               delivered++;
               expect_event(1, b, END_RUN);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: stream words and register writes from the plan
   int  gap = 0;
   int  quiet = 0;
   int  burst = 0;
   always @(posedge clock) begin
      plan_word_t w;
      bit req_busy, csr_busy;
      if (reset) begin
         max_len = 32'hFFFF_FFFF;
         is_head = 0;
         framer_clear();
         req_tvalid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            frame_word(req_tuser, req_tdata);
            words_taken++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAX_BODY) max_len = csr_data;
            else is_head = csr_data[0];
         end
         req_busy = req_tvalid && !req_tready;
         csr_busy = csr_valid && !csr_ready;
         if (frame_events.size() != 0 || (req_tvalid && req_tready)) quiet = 0;
         else quiet++;
         if (!req_busy && !csr_busy) begin
            if (gap > 0) begin
               gap--;
               req_tvalid <= 1'b0;
               csr_valid <= 1'b0;
            end else if (word_plan.size() == 0) begin
               req_tvalid <= 1'b0;
               csr_valid <= 1'b0;
            end else if (word_plan[0].is_csr) begin
               req_tvalid <= 1'b0;
               if (frame_events.size() == 0 && quiet >= 8) begin
                  w = word_plan.pop_front();
                  csr_valid <= 1'b1;
                  csr_index <= w.index;
                  csr_data <= w.value;
               end else csr_valid <= 1'b0;
            end else begin
               w = word_plan.pop_front();
               csr_valid <= 1'b0;
               req_tvalid <= 1'b1;
               req_tuser <= w.kind;
               req_tdata <= w.octet;
               if (burst > 0) begin
                  burst--;
                  gap = 0;
               end else begin
                  gap = pick_gap();
                  if ($urandom_range(0, 199) == 0) burst = $urandom_range(50, 200);
               end
            end
         end
      end
   end

   task automatic report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch at cycle %0d, result %0d: %s got %0h expected %0h",
               cycles, events_seen, what, got, want);
      errors++;
   endtask

   // monitor: random back-pressure and result checking
   int stall = 0;
   int hold = 0;
   bit held = 0;
   always @(posedge clock) begin
      frame_event_t e;
      int r;
      if (reset) rsp_tready <= 1'b0;
      else begin
         if (rsp_tvalid && rsp_tready) begin
            if (frame_events.size() == 0) begin
               $display("unexpected result at cycle %0d: %0h", cycles, rsp_tdata);
               errors++;
            end else begin
               e = frame_events.pop_front();
               if (rsp_tuser !== e.body_valid) report("body_valid", rsp_tuser, e.body_valid);
               if (rsp_tdata[7:0] !== e.body_byte)
                  report("body_byte", rsp_tdata[7:0], e.body_byte);
               if (rsp_tdata[9:8] !== e.end_code)
                  report("end_code", rsp_tdata[9:8], e.end_code);
               if (rsp_tdata[19:10] !== e.status_code)
                  report("status_code", rsp_tdata[19:10], e.status_code);
               if (rsp_tdata[51:20] !== e.body_length)
                  report("body_length", rsp_tdata[51:20], e.body_length);
            end
            events_seen++;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (!held && words_taken > 800) begin
            held = 1;
            hold = 400;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 75) rsp_tready <= 1'b1;
            else begin
               stall = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
               rsp_tready <= 1'b0;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // plan building helpers
   function automatic void add_word(logic [1:0] kind, logic [7:0] b);
      plan_word_t w;
      w.is_csr = 0;
      w.index = 0;
      w.value = 0;
      w.kind = kind;
      w.octet = b;
      word_plan.push_back(w);
   endfunction

   function automatic void add_csr(logic index, logic [31:0] value);
      plan_word_t w;
      w.is_csr = 1;
      w.index = index;
      w.value = value;
      w.kind = KIND_DATA;
      w.octet = 0;
      word_plan.push_back(w);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_word(KIND_DATA, s[i]);
   endfunction

   function automatic void add_noise(int n);
      for (int i = 0; i < n; i++) add_word(KIND_DATA, $urandom_range(0, 255));
   endfunction

   function automatic void begin_response(string status_line);
      add_word(KIND_NEW, $urandom_range(0, 255));
      add_text(status_line);
      responses++;
   endfunction

   function automatic string pick_status();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0: return "HTTP/1.1 100 Continue\r\n";
         1: return $sformatf("HTTP/1.1 1%02d Info\r\n", $urandom_range(0, 99));
         2: return "HTTP/1.1 204 No Content\r\n";
         3: return "HTTP/1.0 304 Not Modified\r\n";
         4: return "HTTP/2.0 200 OK\r\n";
         5: return "HTTP/1.1 -200 OK\r\n";
         6: return "HTTX/1.1 200 OK\r\n";
         7: return $sformatf("HTTP/ 01. 9  %0d\r\n", $urandom_range(0, 99999));
         8: return "HTTP/1.1\r\n";
         default: return $sformatf("HTTP/1.1 %0d OK\r\n", $urandom_range(200, 599));
      endcase
   endfunction

   function automatic string pick_length(int n);
      case ($urandom_range(0, 11))
         0: return "0";
         1: return $sformatf(" 0x%0h", n);
         2: return $sformatf("0%0o", n);
         3: return "-3";
         4: return "99999999999";
         5: return "4294967296";
         6: return "+5";
         7: return "abc";
         default: return $sformatf("%0d", n);
      endcase
   endfunction

   // random response: mostly well formed, some broken or cut short
   function automatic void random_response();
      int framing, n, chunks;
      string st;
      st = pick_status();
      begin_response(st);
      if (st.substr(9, 9) == "1" && $urandom_range(0, 1)) begin
         add_text("X: y\r\n\r\n");
         add_text("HTTP/1.1 200 OK\r\n");
      end
      if ($urandom_range(0, 2) == 0) add_text("Server: unit\r\n");
      if ($urandom_range(0, 24) == 0) add_text("Bad\000hdr\r\n");
      if ($urandom_range(0, 19) == 0) add_text("Content-Length\r\n");
      framing = $urandom_range(0, 2);
      n = $urandom_range(1, 12);
      if (framing == 0) begin
         add_text($urandom_range(0, 5) == 0 ? "Transfer-Encoding: gzip, chunked\r\n"
                                             : "Transfer-Encoding: chunked\r\n");
         add_text("\r\n");
         chunks = $urandom_range(0, 3);
         for (int c = 0; c < chunks; c++) begin
            n = $urandom_range(1, 10);
            add_text($urandom_range(0, 3) == 0 ? $sformatf("%0H;ext\r\n", n)
                                               : $sformatf("%0h\r\n", n));
            add_noise(n);
            add_noise(2);
         end
         add_text($urandom_range(0, 9) == 0 ? "zz\r\n" : "0\r\n\r\n");
      end else if (framing == 1) begin
         add_text({"Content-Length: ", pick_length(n), "\r\n\r\n"});
         add_noise($urandom_range(0, 4) == 0 ? $urandom_range(0, n) : n);
      end else begin
         add_text("\r\n");
         add_noise($urandom_range(0, 12));
      end
      if ($urandom_range(0, 3) == 0) add_word(KIND_CLOSE, $urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) add_word(2'd3, $urandom_range(0, 255));
      if ($urandom_range(0, 15) == 0) add_noise($urandom_range(1, 6));
   endfunction

   function automatic void random_settings();
      int r;
      r = $urandom_range(0, 5);
      add_csr(CSR_MAX_BODY, r == 0 ? 32'd0 : r == 1 ? 32'hFFFF_FFFF :
                            r == 2 ? 32'hFFFF_FFFE : $urandom_range(1, 20));
      add_csr(CSR_IS_HEAD, ($urandom_range(0, 7) == 0) ? 32'd1 : {$urandom} & 32'hFFFF_FFFE);
   endfunction

   initial begin
      int target;
      // scripted part
      add_csr(CSR_MAX_BODY, 32'hFFFF_FFFF);
      add_csr(CSR_IS_HEAD, 32'd0);
      begin_response("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
      add_word(KIND_DATA, 8'h00); add_word(KIND_DATA, 8'hFF); add_word(KIND_DATA, 8'h5A);
      begin_response("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n");
      add_text("4\r\nWiki\r\n0\r\n\r\n");
      begin_response("HTTP/1.0 200 OK\r\n\r\nxy");
      add_word(KIND_CLOSE, 8'h00);
      add_word(KIND_DATA, 8'h41);
      add_word(2'd3, 8'hFF);
      begin_response("HTTP/1.1 100 Continue\r\n\r\nHTTP/1.1 204 No\r\n\r\n");
      begin_response("HTTP/1.1 304 NM\r\nContent-Length: 5\r\n\r\n");
      begin_response("HTTP/1.1 200 OK\r\nContent-Length: 0\r\n\r\n");
      begin_response("HTTP/+1.1 200 OK\r\n\r\n");
      begin_response("HTTP/1.1 200 OK\r\nA: \000\r\n\r\n");
      begin_response("HTTP/1.1 200 OK\r\nContent-Length: -1\r\n\r\n");
      begin_response("HTTP/1.1 200 OK\r\nContent-Length: 99999999999\r\n\r\n");
      begin_response("HTTP/1.1 200 OK\r\nContent-Length\r\nContent-Length: 2\r\n\r\nab");
      begin_response("HTTP/1.1 200 OK\r\nContent-Len");
      add_word(KIND_CLOSE, 8'h00);
      begin_response("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n");
      add_text("\r\n");
      begin_response("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n");
      for (int i = 0; i < CHUNK_LINE; i++) add_word(KIND_DATA, " ");
      begin_response("HTTP/1.1 200 OK\r\n");
      for (int i = 0; i < HDR_LIMIT; i++) add_word(KIND_DATA, "a");
      add_csr(CSR_MAX_BODY, 32'd0);
      add_csr(CSR_IS_HEAD, 32'd1);
      begin_response("HTTP/1.1 200 OK\r\nContent-Length: 4\r\n\r\n");
      add_csr(CSR_IS_HEAD, 32'd0);
      begin_response("HTTP/1.1 999999 OK\r\n\r\nz");
      add_csr(CSR_MAX_BODY, 32'd3);
      begin_response("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n2\r\nab\r\n2\r\n");

      // random part
      target = word_plan.size() + 1800;
      while (word_plan.size() < target) begin
         if ($urandom_range(0, 11) == 0) random_settings();
         random_response();
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (word_plan.size() == 0 && !req_tvalid && !csr_valid);
      wait (frame_events.size() == 0);
      repeat (20) @(posedge clock);
      $display("%0d words over %0d responses accepted, %0d results checked",
               words_taken, responses, events_seen);
      $display("framing by length, chunks and close, with head and length limits varied");
      if (errors == 0 && frame_events.size() == 0) $display("ALL CHECKS PASSED");
      else begin
         $display("%0d mismatches, %0d results never arrived", errors, frame_events.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: http_response_framer.f
hdl/hrf_pkg.sv
hdl/hrf_core.sv
hdl/hrf_out_buf.sv
hdl/http_response_framer.sv
tb/testbench.sv
